>>> design/smeu_pkg.sv
// Shared opcodes, status codes, sizes and types of the stack machine execute unit.
`timescale 1ns / 1ps
`default_nettype none

package smeu_pkg;

    localparam int DATA_DEPTH   = 64;
    localparam int RETURN_DEPTH = 32;
    localparam int REG_COUNT    = 8;
    localparam int RAM_WORDS    = 1024;
    localparam int VRAM_BYTES   = 4096;

    localparam int DS_AW  = $clog2(DATA_DEPTH);
    localparam int DS_CW  = $clog2(DATA_DEPTH + 1);
    localparam int RS_AW  = $clog2(RETURN_DEPTH);
    localparam int RS_CW  = $clog2(RETURN_DEPTH + 1);
    localparam int RF_AW  = $clog2(REG_COUNT);
    localparam int RAM_AW = $clog2(RAM_WORDS);
    localparam int VR_AW  = $clog2(VRAM_BYTES);
    localparam int CLR_LEN = (RAM_WORDS > VRAM_BYTES) ? RAM_WORDS : VRAM_BYTES;
    localparam int CLR_AW  = $clog2(CLR_LEN);

    localparam int PC_W   = 16;
    localparam int WORD_W = 32;
    localparam int OP_W   = 7;
    localparam int PLEN_W = 17;
    localparam int DIM_W  = 7;

    localparam logic [OP_W-1:0] OP_PUSH   = 7'd1;
    localparam logic [OP_W-1:0] OP_POP    = 7'd2;
    localparam logic [OP_W-1:0] OP_ADD    = 7'd3;
    localparam logic [OP_W-1:0] OP_SUB    = 7'd4;
    localparam logic [OP_W-1:0] OP_MUL    = 7'd5;
    localparam logic [OP_W-1:0] OP_DIV    = 7'd6;
    localparam logic [OP_W-1:0] OP_SQRT   = 7'd7;
    localparam logic [OP_W-1:0] OP_OUT    = 7'd8;
    localparam logic [OP_W-1:0] OP_HLT    = 7'd9;
    localparam logic [OP_W-1:0] OP_IN     = 7'd10;
    localparam logic [OP_W-1:0] OP_PUSHR  = 7'd11;
    localparam logic [OP_W-1:0] OP_POPR   = 7'd12;
    localparam logic [OP_W-1:0] OP_JMP    = 7'd22;
    localparam logic [OP_W-1:0] OP_JB     = 7'd23;
    localparam logic [OP_W-1:0] OP_JBE    = 7'd24;
    localparam logic [OP_W-1:0] OP_JA     = 7'd25;
    localparam logic [OP_W-1:0] OP_JAE    = 7'd26;
    localparam logic [OP_W-1:0] OP_JE     = 7'd27;
    localparam logic [OP_W-1:0] OP_JNE    = 7'd28;
    localparam logic [OP_W-1:0] OP_CALL   = 7'd29;
    localparam logic [OP_W-1:0] OP_RET    = 7'd30;
    localparam logic [OP_W-1:0] OP_PUSHM  = 7'd41;
    localparam logic [OP_W-1:0] OP_POPM   = 7'd42;
    localparam logic [OP_W-1:0] OP_DRAW   = 7'd51;
    localparam logic [OP_W-1:0] OP_PUSHV  = 7'd61;
    localparam logic [OP_W-1:0] OP_POPV   = 7'd62;
    localparam logic [OP_W-1:0] OP_DRAWV  = 7'd71;
    localparam logic [OP_W-1:0] OP_CIRCLE = 7'd72;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_STACK   = 3'd1;
    localparam logic [2:0] ST_DIV0    = 3'd2;
    localparam logic [2:0] ST_MODE    = 3'd3;
    localparam logic [2:0] ST_COORD   = 3'd4;
    localparam logic [2:0] ST_PC_OUT  = 3'd5;
    localparam logic [2:0] ST_BAD_OP  = 3'd6;

    localparam logic [1:0] CFG_PLEN   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic start;
        logic is_sqrt;
    } t_dsu_req;

endpackage

`default_nettype wire

>>> design/smeu_divsqrt.sv
// Iterative signed divider and integer square root, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module smeu_divsqrt
    import smeu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dsu_req          i_req,
    input  wire logic [WORD_W-1:0] i_num,
    input  wire logic [WORD_W-1:0] i_den,
    output logic                   o_done,
    output logic [WORD_W-1:0]      o_result
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic              r_sqrt, n_sqrt;
    logic              r_neg, n_neg;
    logic [4:0]        r_cnt, n_cnt;
    logic [WORD_W-1:0] r_q, n_q;
    logic [WORD_W:0]   r_rem, n_rem;
    logic [WORD_W-1:0] r_den, n_den;
    logic [WORD_W-1:0] r_bit, n_bit;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   sq_sum;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_sqrt = r_sqrt;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        n_bit  = r_bit;
        trial  = {r_rem[WORD_W-1:0], r_q[WORD_W-1]};
        sq_sum = {1'b0, r_q} + {1'b0, r_bit};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_sqrt = i_req.is_sqrt;
            n_neg  = i_num[WORD_W-1] ^ i_den[WORD_W-1];
            n_rem  = '0;
            n_bit  = WORD_W'(32'h4000_0000);
            if (i_req.is_sqrt) begin
                // Root accumulates in q; the remainder holds the radicand.
                n_q   = '0;
                n_rem = {1'b0, i_num};
                n_cnt = 5'd15;
            end else begin
                n_q   = i_num[WORD_W-1] ? (0 - i_num) : i_num;
                n_den = i_den[WORD_W-1] ? (0 - i_den) : i_den;
                n_cnt = 5'd31;
            end
        end else if (r_busy) begin
            if (r_sqrt) begin
                if (r_rem >= sq_sum) begin
                    n_rem = r_rem - sq_sum;
                    n_q   = (r_q >> 1) + r_bit;
                end else begin
                    n_q = r_q >> 1;
                end
                n_bit = r_bit >> 2;
            end else begin
                if (trial >= {1'b0, r_den}) begin
                    n_rem = trial - {1'b0, r_den};
                    n_q   = {r_q[WORD_W-2:0], 1'b1};
                end else begin
                    n_rem = trial;
                    n_q   = {r_q[WORD_W-2:0], 1'b0};
                end
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_sqrt <= n_sqrt;
        r_neg  <= n_neg;
        r_cnt  <= n_cnt;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_bit  <= n_bit;
    end

    assign o_done   = r_done;
    assign o_result = (!r_sqrt && r_neg) ? (0 - r_q) : r_q;

endmodule

`default_nettype wire

>>> design/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit: sequencer, stacks, RAMs and registers.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | tdata (low bit up)                         | tuser
// ----------+-----------+--------------------------------------------+--------------------
// s_axis    | in        | first_operand, second_operand, input_value | action
// m_axis    | out       | next_pc, out_value, status (zero padded)   | out_valid, halted
// cfg       | in        | write enable, index, 17-bit data           | -
//
// Each request passes from acceptance to a result in the output register through these steps:
// two data stack reads through the single read port of the stack memory, an execute
// step with the write-back, and the load of the output register. DIV and SQRT also
// wait on the bit-serial divide/root unit. After reset a clearing pass zeroes the
// word RAM and video RAM; no request is taken meanwhile, configuration writes are.
// A stalled result holds in the output register while the next request is already
// being executed.

module stack_machine_execute_unit
    import smeu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // first_operand [31:0], second_operand [63:32], input_value [95:64]
    input  wire logic [95:0]       i_s_axis_tdata,
    // action [6:0]
    input  wire logic [OP_W-1:0]   i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    // next_pc [15:0], out_value [47:16], status [50:48], zeros [55:51]
    output logic [55:0]            o_m_axis_tdata,
    // out_valid [0], halted [1]
    output logic [1:0]             o_m_axis_tuser,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [PLEN_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RD1, S_RD2, S_EXEC, S_ITER, S_DONE
    } t_state;

    t_state r_state, n_state;

    // Architectural state held in flip-flops.
    logic [PC_W-1:0]   r_pc, n_pc;
    logic [DS_CW-1:0]  r_dcnt, n_dcnt;
    logic [RS_CW-1:0]  r_rcnt, n_rcnt;
    logic [WORD_W-1:0] r_regs [REG_COUNT];
    logic [PLEN_W-1:0] r_plen;
    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic [CLR_AW-1:0] r_clr, n_clr;

    // The request being executed.
    logic [OP_W-1:0]   r_op, n_op;
    logic [WORD_W-1:0] r_p1, n_p1;
    logic [WORD_W-1:0] r_p2, n_p2;
    logic [WORD_W-1:0] r_iv, n_iv;
    logic [WORD_W-1:0] r_a, n_a;
    logic [DS_AW-1:0]  r_push_idx, n_push_idx;

    // Result waiting for the output register.
    logic [PC_W-1:0]   r_res_pc, n_res_pc;
    logic [WORD_W-1:0] r_res_val, n_res_val;
    logic              r_res_ov, n_res_ov;
    logic              r_res_halt, n_res_halt;
    logic [2:0]        r_res_st, n_res_st;

    // Output register.
    logic              r_ov, n_ov;
    logic [PC_W-1:0]   r_o_pc, n_o_pc;
    logic [WORD_W-1:0] r_o_val, n_o_val;
    logic              r_o_outv, n_o_outv;
    logic              r_o_halt, n_o_halt;
    logic [2:0]        r_o_st, n_o_st;

    // Memories with registered read data.
    logic [WORD_W-1:0] ds_mem [DATA_DEPTH];
    logic [PC_W-1:0]   rs_mem [RETURN_DEPTH];
    logic [WORD_W-1:0] wr_mem [RAM_WORDS];
    logic [7:0]        vr_mem [VRAM_BYTES];
    logic [WORD_W-1:0] ds_q;
    logic [PC_W-1:0]   rs_q;
    logic [WORD_W-1:0] wr_q;
    logic [7:0]        vr_q;

    logic              ds_re, ds_we;
    logic [DS_AW-1:0]  ds_raddr, ds_waddr;
    logic [WORD_W-1:0] ds_wdata;
    logic              rs_re, rs_we;
    logic [RS_AW-1:0]  rs_waddr;
    logic              mem_re, wr_we, vr_we;
    logic [RAM_AW-1:0] wr_addr, wr_waddr;
    logic [WORD_W-1:0] wr_wdata;
    logic [VR_AW-1:0]  vr_addr, vr_waddr;
    logic [7:0]        vr_wdata;
    logic              rf_we;
    logic [RF_AW-1:0]  rf_idx;

    logic              in_accept;
    logic [PC_W-1:0]   pc1, pc2, pc3;
    logic [DS_CW-1:0]  dcnt_m1, dcnt_m2;
    logic [RS_CW-1:0]  rcnt_m1;
    logic              tgt_out;
    logic              take;
    logic              coord_bad;
    logic [WORD_W-1:0] reg_p1;
    logic [WORD_W-1:0] arith;
    t_dsu_req          dsu_req;
    logic              dsu_done;
    logic [WORD_W-1:0] dsu_result;

    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);

    assign pc1     = r_pc + PC_W'(1);
    assign pc2     = r_pc + PC_W'(2);
    assign pc3     = r_pc + PC_W'(3);
    assign dcnt_m1 = r_dcnt - DS_CW'(1);
    assign dcnt_m2 = r_dcnt - DS_CW'(2);
    assign rcnt_m1 = r_rcnt - RS_CW'(1);
    assign rf_idx  = r_p1[RF_AW-1:0];
    assign reg_p1  = r_regs[rf_idx];
    assign tgt_out = (r_p1 >= {{(WORD_W-PLEN_W){1'b0}}, r_plen});

    // Address mode 1 takes the RAM address from a register; both wrap to the RAM size.
    assign wr_addr = (r_p1 == WORD_W'(1)) ? r_regs[r_p2[RF_AW-1:0]][RAM_AW-1:0]
                                          : r_p2[RAM_AW-1:0];
    // Only six bits of each coordinate enter the address, though the width and height limits allow up to 126.
    assign vr_addr = VR_AW'({6'd0, r_p1[5:0]}) + VR_AW'(r_p2[5:0] * r_width);
    assign coord_bad = (r_p1 >= {{(WORD_W-DIM_W){1'b0}}, r_width}) ||
                       (r_p2 >= {{(WORD_W-DIM_W){1'b0}}, r_height});

    always_comb begin
        case (r_op)
            OP_JB:   take = $signed(ds_q) < $signed(r_a);
            OP_JBE:  take = !($signed(r_a) < $signed(ds_q));
            OP_JA:   take = $signed(r_a) < $signed(ds_q);
            OP_JAE:  take = !($signed(ds_q) < $signed(r_a));
            OP_JE:   take = (r_a == ds_q);
            OP_JNE:  take = (r_a != ds_q);
            default: take = 1'b0;
        endcase
        case (r_op)
            OP_ADD:  arith = ds_q + r_a;
            OP_SUB:  arith = ds_q - r_a;
            default: arith = ds_q * r_a;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_pc       = r_pc;
        n_dcnt     = r_dcnt;
        n_rcnt     = r_rcnt;
        n_clr      = r_clr;
        n_op       = r_op;
        n_p1       = r_p1;
        n_p2       = r_p2;
        n_iv       = r_iv;
        n_a        = r_a;
        n_push_idx = r_push_idx;
        n_res_pc   = r_res_pc;
        n_res_val  = r_res_val;
        n_res_ov   = r_res_ov;
        n_res_halt = r_res_halt;
        n_res_st   = r_res_st;
        n_ov       = r_ov && !i_m_axis_tready;
        n_o_pc     = r_o_pc;
        n_o_val    = r_o_val;
        n_o_outv   = r_o_outv;
        n_o_halt   = r_o_halt;
        n_o_st     = r_o_st;

        ds_re    = 1'b0;
        ds_raddr = dcnt_m1[DS_AW-1:0];
        ds_we    = 1'b0;
        ds_waddr = r_dcnt[DS_AW-1:0];
        ds_wdata = '0;
        rs_re    = 1'b0;
        rs_we    = 1'b0;
        rs_waddr = r_rcnt[RS_AW-1:0];
        mem_re   = 1'b0;
        wr_we    = 1'b0;
        wr_waddr = wr_addr;
        wr_wdata = r_a;
        vr_we    = 1'b0;
        vr_waddr = vr_addr;
        vr_wdata = r_a[7:0];
        rf_we    = 1'b0;
        dsu_req  = '{start: 1'b0, is_sqrt: 1'b0};

        case (r_state)
            S_CLEAR: begin
                wr_we    = 1'b1;
                wr_waddr = r_clr[RAM_AW-1:0];
                wr_wdata = '0;
                vr_we    = 1'b1;
                vr_waddr = r_clr[VR_AW-1:0];
                vr_wdata = '0;
                n_clr    = r_clr + CLR_AW'(1);
                if (r_clr == CLR_AW'(CLR_LEN - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_op    = i_s_axis_tuser;
                    n_p1    = i_s_axis_tdata[31:0];
                    n_p2    = i_s_axis_tdata[63:32];
                    n_iv    = i_s_axis_tdata[95:64];
                    n_state = S_RD1;
                end
            end
            S_RD1: begin
                // Top of stack, return stack top and both RAMs are read together.
                ds_re   = 1'b1;
                rs_re   = 1'b1;
                mem_re  = 1'b1;
                n_state = S_RD2;
            end
            S_RD2: begin
                n_a      = ds_q;
                ds_re    = 1'b1;
                ds_raddr = dcnt_m2[DS_AW-1:0];
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                n_res_pc   = pc1;
                n_res_val  = '0;
                n_res_ov   = 1'b0;
                n_res_halt = 1'b0;
                n_res_st   = ST_OK;
                n_state    = S_DONE;
                case (r_op)
                    OP_PUSH, OP_IN, OP_PUSHR: begin
                        if (r_op != OP_IN) begin
                            n_res_pc = pc2;
                        end
                        if (r_dcnt >= DS_CW'(DATA_DEPTH)) begin
                            n_res_st = ST_STACK;
                        end else begin
                            ds_we    = 1'b1;
                            ds_wdata = (r_op == OP_PUSH) ? r_p1 :
                                       (r_op == OP_IN) ? r_iv : reg_p1;
                            n_dcnt   = r_dcnt + DS_CW'(1);
                        end
                    end
                    OP_POP, OP_OUT, OP_POPR: begin
                        if (r_op == OP_POPR) begin
                            n_res_pc = pc2;
                        end
                        if (r_dcnt == '0) begin
                            n_res_st = ST_STACK;
                        end else begin
                            n_dcnt = dcnt_m1;
                            if (r_op == OP_OUT) begin
                                n_res_val = r_a;
                                n_res_ov  = 1'b1;
                            end
                            rf_we = (r_op == OP_POPR);
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                        if (r_dcnt < DS_CW'(2)) begin
                            n_res_st = ST_STACK;
                        end else if (r_op == OP_DIV) begin
                            n_dcnt = dcnt_m2;
                            if (r_a == '0) begin
                                n_res_st = ST_DIV0;
                            end else begin
                                dsu_req    = '{start: 1'b1, is_sqrt: 1'b0};
                                n_push_idx = dcnt_m2[DS_AW-1:0];
                                n_dcnt     = dcnt_m1;
                                n_state    = S_ITER;
                            end
                        end else begin
                            ds_we    = 1'b1;
                            ds_waddr = dcnt_m2[DS_AW-1:0];
                            ds_wdata = arith;
                            n_dcnt   = dcnt_m1;
                        end
                    end
                    OP_SQRT: begin
                        if (r_dcnt == '0) begin
                            n_res_st = ST_STACK;
                        end else if (r_a[WORD_W-1]) begin
                            n_res_st = ST_DIV0;
                            n_dcnt   = dcnt_m1;
                        end else begin
                            dsu_req    = '{start: 1'b1, is_sqrt: 1'b1};
                            n_push_idx = dcnt_m1[DS_AW-1:0];
                            n_state    = S_ITER;
                        end
                    end
                    OP_HLT: begin
                        n_res_halt = 1'b1;
                    end
                    OP_JMP: begin
                        n_res_pc = r_p1[PC_W-1:0];
                        if (tgt_out) begin
                            n_res_st = ST_PC_OUT;
                        end
                    end
                    OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE: begin
                        n_res_pc = pc2;
                        if (r_dcnt < DS_CW'(2)) begin
                            n_res_st = ST_STACK;
                        end else begin
                            n_dcnt = dcnt_m2;
                            if (take) begin
                                n_res_pc = r_p1[PC_W-1:0];
                                if (tgt_out) begin
                                    n_res_st = ST_PC_OUT;
                                end
                            end
                        end
                    end
                    OP_CALL: begin
                        n_res_pc = pc2;
                        if (r_rcnt >= RS_CW'(RETURN_DEPTH)) begin
                            n_res_st = ST_STACK;
                        end else begin
                            rs_we    = 1'b1;
                            n_rcnt   = r_rcnt + RS_CW'(1);
                            n_res_pc = r_p1[PC_W-1:0];
                            if (tgt_out) begin
                                n_res_st = ST_PC_OUT;
                            end
                        end
                    end
                    OP_RET: begin
                        if (r_rcnt == '0) begin
                            n_res_st = ST_STACK;
                        end else begin
                            n_rcnt   = rcnt_m1;
                            n_res_pc = rs_q;
                            if ({1'b0, rs_q} >= r_plen) begin
                                n_res_st = ST_PC_OUT;
                            end
                        end
                    end
                    OP_PUSHM, OP_POPM: begin
                        n_res_pc = pc3;
                        if (r_p1 > WORD_W'(1)) begin
                            n_res_st = ST_MODE;
                        end else if (r_op == OP_PUSHM) begin
                            if (r_dcnt >= DS_CW'(DATA_DEPTH)) begin
                                n_res_st = ST_STACK;
                            end else begin
                                ds_we    = 1'b1;
                                ds_wdata = wr_q;
                                n_dcnt   = r_dcnt + DS_CW'(1);
                            end
                        end else begin
                            if (r_dcnt == '0) begin
                                n_res_st = ST_STACK;
                            end else begin
                                wr_we  = 1'b1;
                                n_dcnt = dcnt_m1;
                            end
                        end
                    end
                    OP_PUSHV, OP_POPV: begin
                        n_res_pc = pc3;
                        if (coord_bad) begin
                            n_res_st = ST_COORD;
                        end else if (r_op == OP_PUSHV) begin
                            if (r_dcnt >= DS_CW'(DATA_DEPTH)) begin
                                n_res_st = ST_STACK;
                            end else begin
                                ds_we    = 1'b1;
                                ds_wdata = {{(WORD_W-8){vr_q[7]}}, vr_q};
                                n_dcnt   = r_dcnt + DS_CW'(1);
                            end
                        end else begin
                            if (r_dcnt == '0) begin
                                n_res_st = ST_STACK;
                            end else begin
                                vr_we  = 1'b1;
                                n_dcnt = dcnt_m1;
                            end
                        end
                    end
                    OP_DRAW, OP_DRAWV: begin
                    end
                    OP_CIRCLE: begin
                        n_res_pc = pc2;
                    end
                    default: begin
                        n_res_st = ST_BAD_OP;
                    end
                endcase
                n_pc = n_res_pc;
            end
            S_ITER: begin
                if (dsu_done) begin
                    ds_we    = 1'b1;
                    ds_waddr = r_push_idx;
                    ds_wdata = dsu_result;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ov || i_m_axis_tready) begin
                    n_ov     = 1'b1;
                    n_o_pc   = r_res_pc;
                    n_o_val  = r_res_val;
                    n_o_outv = r_res_ov;
                    n_o_halt = r_res_halt;
                    n_o_st   = r_res_st;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer state, architectural counters, configuration, request, result and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_pc     <= '0;
            r_dcnt   <= '0;
            r_rcnt   <= '0;
            r_clr    <= '0;
            r_ov     <= 1'b0;
            r_plen   <= PLEN_W'(1024);
            r_width  <= DIM_W'(10);
            r_height <= DIM_W'(10);
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_dcnt  <= n_dcnt;
            r_rcnt  <= n_rcnt;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_PLEN:   r_plen   <= i_cfg_data;
                    CFG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                    CFG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        r_op       <= n_op;
        r_p1       <= n_p1;
        r_p2       <= n_p2;
        r_iv       <= n_iv;
        r_a        <= n_a;
        r_push_idx <= n_push_idx;
        r_res_pc   <= n_res_pc;
        r_res_val  <= n_res_val;
        r_res_ov   <= n_res_ov;
        r_res_halt <= n_res_halt;
        r_res_st   <= n_res_st;
        r_o_pc     <= n_o_pc;
        r_o_val    <= n_o_val;
        r_o_outv   <= n_o_outv;
        r_o_halt   <= n_o_halt;
        r_o_st     <= n_o_st;
    end

    // Register file: small enough for flip-flops cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= '0;
            end
        end else if (rf_we) begin
            r_regs[rf_idx] <= r_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ds_we) begin
            ds_mem[ds_waddr] <= ds_wdata;
        end
        if (ds_re) begin
            ds_q <= ds_mem[ds_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rs_we) begin
            rs_mem[rs_waddr] <= pc2;
        end
        if (rs_re) begin
            rs_q <= rs_mem[rcnt_m1[RS_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_we) begin
            wr_mem[wr_waddr] <= wr_wdata;
        end
        if (mem_re) begin
            wr_q <= wr_mem[wr_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (vr_we) begin
            vr_mem[vr_waddr] <= vr_wdata;
        end
        if (mem_re) begin
            vr_q <= vr_mem[vr_addr];
        end
    end

    smeu_divsqrt u_divsqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (dsu_req),
        .i_num    (r_op == OP_SQRT ? r_a : ds_q),
        .i_den    (r_a),
        .o_done   (dsu_done),
        .o_result (dsu_result)
    );

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {5'd0, r_o_st, r_o_val, r_o_pc};
    assign o_m_axis_tuser  = {r_o_halt, r_o_outv};

    // The stack counters never pass the depth of their memories.
    a_dcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dcnt <= DS_CW'(DATA_DEPTH))
        else $error("data stack count beyond depth");

    a_rcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcnt <= RS_CW'(RETURN_DEPTH))
        else $error("return stack count beyond depth");

    // No request may enter while the RAMs are still being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_axis_tready)
        else $error("request accepted during clearing pass");

    // The divide/root unit only finishes while the sequencer waits for it.
    a_dsu_done_in_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dsu_done |-> (r_state == S_ITER))
        else $error("divide/root result outside wait state");

endmodule

`default_nettype wire
